[hw/rtl/ktc_pkg.sv]
// ----------------------------------------------------------------------------
// ktc_pkg
// Shared constants, types and register codes of the key twinkle colour
// generator.
// ----------------------------------------------------------------------------
package ktc_pkg;

  localparam int KEY_COUNT    = 256;
  localparam int SINE_ENTRIES = 1024;  // power of two, 64 .. 65536
  localparam int SINE_LOG2    = $clog2(SINE_ENTRIES);

  // Keeps the quadrant fraction bits that the sine step resolves.
  localparam logic [15:0] Z_MASK = 16'hFFFF << (18 - SINE_LOG2);

  localparam logic [31:0] HASH_MUL1 = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL2 = 32'h846ca68b;

  // Phase offset: hash mod PHASE_MOD, scaled to Q0.24.
  localparam int PHASE_MOD = 10000;
  localparam int DIV_SHIFT = 45;
  localparam int QUO_W     = 64 - DIV_SHIFT;
  localparam logic [31:0] DIV_MAGIC =
    32'(((64'd1 << DIV_SHIFT) + 64'(PHASE_MOD) - 64'd1) / 64'(PHASE_MOD));
  localparam int REM_W     = 14;
  localparam int OFF_SHIFT = 23;
  localparam logic [33:0] OFF_MUL =
    34'(((64'd1 << (24 + OFF_SHIFT)) + 64'(PHASE_MOD) - 64'd1) / 64'(PHASE_MOD));

  localparam logic [16:0] ONE16    = 17'd65536;
  localparam logic [16:0] POLY_A   = 17'd102944;
  localparam logic [15:0] POLY_B   = 16'd42048;
  localparam logic [12:0] POLY_C   = 13'd4640;
  localparam logic [17:0] SMOOTH_K = 18'd196608;
  localparam logic [24:0] ROUND_HALF = 25'd32768;

  // Quotient bits of the brightness divider, one per stage.
  localparam int Q_W = 17;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam logic [QUEUE_AW:0] QUEUE_FULL = {1'b1, {QUEUE_AW{1'b0}}};

  typedef enum logic [2:0] {
    REG_STAR_RED     = 3'd0,
    REG_STAR_GREEN   = 3'd1,
    REG_STAR_BLUE    = 3'd2,
    REG_BACK_RED     = 3'd3,
    REG_BACK_GREEN   = 3'd4,
    REG_BACK_BLUE    = 3'd5,
    REG_LIT_FRACTION = 3'd6,
    REG_RATE_SCALE   = 3'd7
  } ktc_reg_t;

  typedef struct packed {
    logic [7:0]  star_red;
    logic [7:0]  star_green;
    logic [7:0]  star_blue;
    logic [7:0]  back_red;
    logic [7:0]  back_green;
    logic [7:0]  back_blue;
    logic [16:0] lit_fraction;
    logic [15:0] rate_scale;
  } ktc_cfg_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [7:0]  key;
    logic [23:0] phase;
    logic        on_board;
  } ktc_item_t;

  typedef struct packed {
    logic [7:0] key;
    logic       live;
  } ktc_tag_t;

endpackage

[hw/rtl/ktc_front.sv]
// ----------------------------------------------------------------------------
// ktc_front
// Accepts key requests, hashes the key to a phase offset and forms the
// Q0.24 phase of each key.
// ----------------------------------------------------------------------------
module ktc_front import ktc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ktc_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key,
  input  logic [31:0] in_stamp,
  output logic        push,
  output ktc_item_t   push_data,
  input  logic        queue_full
);

  logic              en;
  logic [5:0]        vld;
  logic [31:0]       hx0;
  logic [31:0]       mix1, mix2, hash3, hash4;
  logic [7:0]        key1, key2, key3, key4, key5, key6;
  logic [31:0]       stamp1, stamp2;
  logic [39:0]       frac_prod;
  logic [23:0]       frac3, frac4, frac5, frac6;
  logic [63:0]       quo_prod;
  logic [QUO_W-1:0]  quo4;
  logic [31:0]       rem_full;
  logic [REM_W-1:0]  rem5;
  logic [47:0]       off_prod;
  logic [23:0]       off6;

  assign en       = !(vld[5] && queue_full);
  assign in_ready = en;
  assign push     = vld[5] && !queue_full;

  assign hx0       = (32'(in_key) + 32'd1) ^ ((32'(in_key) + 32'd1) >> 16);
  assign frac_prod = stamp2[23:0] * cfg.rate_scale;
  assign quo_prod  = {32'b0, hash3} * {32'b0, DIV_MAGIC};
  assign rem_full  = hash4 - 32'({13'b0, quo4} * 32'(PHASE_MOD));
  assign off_prod  = {34'b0, rem5} * {14'b0, OFF_MUL};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key1   <= in_key;
      stamp1 <= in_stamp;
      mix1   <= 32'(hx0 * HASH_MUL1);

      key2   <= key1;
      stamp2 <= stamp1;
      mix2   <= 32'((mix1 ^ (mix1 >> 15)) * HASH_MUL2);

      key3   <= key2;
      hash3  <= mix2 ^ (mix2 >> 16);
      frac3  <= frac_prod[23:0];

      key4   <= key3;
      hash4  <= hash3;
      frac4  <= frac3;
      quo4   <= quo_prod[63:DIV_SHIFT];

      key5   <= key4;
      frac5  <= frac4;
      rem5   <= rem_full[REM_W-1:0];

      key6   <= key5;
      frac6  <= frac5;
      off6   <= off_prod[OFF_SHIFT+23:OFF_SHIFT];
    end
  end

  assign push_data.key      = key6;
  assign push_data.phase    = frac6 + off6;
  assign push_data.on_board = 32'(key6) < 32'(KEY_COUNT);

endmodule

[hw/rtl/ktc_queue.sv]
// ----------------------------------------------------------------------------
// ktc_queue
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module ktc_queue import ktc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ktc_item_t push_data,
  output logic      full,
  input  logic      pop,
  output ktc_item_t pop_data,
  output logic      empty
);

  ktc_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full     = count == QUEUE_FULL;
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/ktc_div.sv]
// ----------------------------------------------------------------------------
// ktc_div
// Pipelined restoring divider, one quotient bit per stage, giving the
// Q0.16 brightness from the excess over the lit threshold.
// ----------------------------------------------------------------------------
module ktc_div import ktc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ktc_tag_t       in_tag,
  input  logic [17:0]    in_num,
  input  logic [16:0]    divisor,
  output logic           out_valid,
  output ktc_tag_t       out_tag,
  output logic [Q_W-1:0] out_quo
);

  logic [Q_W-1:0] vld;
  logic [Q_W-1:0] rem_q   [Q_W];
  logic [Q_W-1:0] low_q   [Q_W];
  logic [Q_W-1:0] quo_q   [Q_W];
  ktc_tag_t       tag_q   [Q_W];
  logic [Q_W-1:0] rem_src [Q_W];
  logic [Q_W-1:0] low_src [Q_W];
  logic [Q_W-1:0] quo_src [Q_W];
  logic [Q_W-1:0] rem_nx  [Q_W];
  logic [Q_W-1:0] low_nx  [Q_W];
  logic [Q_W-1:0] quo_nx  [Q_W];
  logic [Q_W:0]   cand    [Q_W];
  logic [Q_W-1:0] ge;

  // Dividend is in_num << 15; its top part already sits below the divisor.
  always_comb begin
    rem_src[0] = {1'b0, in_num[17:2]};
    low_src[0] = {in_num[1:0], 15'b0};
    quo_src[0] = '0;
    for (int k = 1; k < Q_W; k++) begin
      rem_src[k] = rem_q[k-1];
      low_src[k] = low_q[k-1];
      quo_src[k] = quo_q[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      cand[k]   = {rem_src[k], low_src[k][Q_W-1]};
      ge[k]     = cand[k] >= {1'b0, divisor};
      rem_nx[k] = ge[k] ? Q_W'(cand[k] - {1'b0, divisor}) : cand[k][Q_W-1:0];
      low_nx[k] = {low_src[k][Q_W-2:0], 1'b0};
      quo_nx[k] = {quo_src[k][Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= in_tag;
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k] <= rem_nx[k];
        low_q[k] <= low_nx[k];
        quo_q[k] <= quo_nx[k];
      end
      for (int k = 1; k < Q_W; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_tag   = tag_q[Q_W-1];
  assign out_quo   = quo_q[Q_W-1];

endmodule

[hw/rtl/ktc_back.sv]
// ----------------------------------------------------------------------------
// ktc_back
// Sine wave, lit test, brightness division, smoothstep and colour blend,
// ending in the output register.
// ----------------------------------------------------------------------------
module ktc_back import ktc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ktc_cfg_t  cfg,
  output logic      pop,
  input  logic      empty,
  input  ktc_item_t head,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_key,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic        en;
  logic [5:0]  vld_a;
  logic [2:0]  vld_c;
  logic [15:0] z_raw;
  logic [1:0]  q1, q2, q3, q4;
  logic [16:0] z1, z2, z3, z4;
  logic [16:0] sq2, sq3;
  logic [12:0] t3;
  logic [15:0] u4;
  logic [17:0] w5;
  logic [17:0] x6;
  ktc_tag_t    tag1, tag2, tag3, tag4, tag5, tag6;
  logic [33:0] sq_prod;
  logic [29:0] t_prod;
  logic [32:0] u_prod;
  logic [33:0] s_prod;
  logic [16:0] s_mag;
  logic [16:0] d_eff;
  logic [17:0] thr;
  logic        div_valid;
  ktc_tag_t    div_tag;
  logic [16:0] div_quo;
  logic [16:0] b_sel, b7;
  logic [33:0] bb_prod;
  logic [16:0] bb7;
  logic [7:0]  key7, key8;
  logic [34:0] e_prod;
  logic [16:0] e8;

  function automatic logic [7:0] blend_ch(input logic [7:0] back, input logic [7:0] star,
                                          input logic [16:0] e);
    logic [24:0] acc;
    acc = back * (ONE16 - e) + star * e + ROUND_HALF;
    return acc[23:16];
  endfunction

  assign en        = !out_valid || out_ready;
  assign pop       = en && !empty;
  assign out_valid = vld_c[2];

  assign z_raw   = head.phase[21:6] & Z_MASK;
  assign sq_prod = z1 * z1;
  assign t_prod  = sq2 * POLY_C;
  assign u_prod  = sq3 * (POLY_B - {3'b0, t3});
  assign s_prod  = z4 * (POLY_A - {1'b0, u4});
  assign s_mag   = (s_prod[32:16] > ONE16) ? ONE16 : s_prod[32:16];
  assign d_eff   = (cfg.lit_fraction > ONE16) ? ONE16 : cfg.lit_fraction;
  assign thr     = {ONE16, 1'b0} - {d_eff, 1'b0};
  assign b_sel   = div_tag.live ? div_quo : '0;
  assign bb_prod = b_sel * b_sel;
  assign e_prod  = bb7 * (SMOOTH_K - {b7, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
      vld_c <= '0;
    end else if (en) begin
      vld_a <= {vld_a[4:0], pop};
      vld_c <= {vld_c[1:0], div_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quadrant and distance into it; odd quadrants run backwards
      q1   <= head.phase[23:22];
      z1   <= head.phase[22] ? (ONE16 - {1'b0, z_raw}) : {1'b0, z_raw};
      tag1 <= '{key: head.key, live: head.on_board};

      q2   <= q1;
      z2   <= z1;
      sq2  <= sq_prod[32:16];
      tag2 <= tag1;

      q3   <= q2;
      z3   <= z2;
      sq3  <= sq2;
      t3   <= t_prod[28:16];
      tag3 <= tag2;

      q4   <= q3;
      z4   <= z3;
      u4   <= u_prod[31:16];
      tag4 <= tag3;

      w5   <= q4[1] ? ({1'b0, ONE16} - {1'b0, s_mag}) : ({1'b0, ONE16} + {1'b0, s_mag});
      tag5 <= tag4;

      x6   <= w5 - thr;
      tag6 <= '{key: tag5.key, live: tag5.live && (w5 > thr)};

      b7   <= b_sel;
      bb7  <= bb_prod[32:16];
      key7 <= div_tag.key;

      e8   <= (e_prod[34:16] > 19'(ONE16)) ? ONE16 : e_prod[32:16];
      key8 <= key7;

      out_key   <= key8;
      out_red   <= blend_ch(cfg.back_red, cfg.star_red, e8);
      out_green <= blend_ch(cfg.back_green, cfg.star_green, e8);
      out_blue  <= blend_ch(cfg.back_blue, cfg.star_blue, e8);
    end
  end

  ktc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld_a[5]),
    .in_tag    (tag6),
    .in_num    (x6),
    .divisor   (d_eff),
    .out_valid (div_valid),
    .out_tag   (div_tag),
    .out_quo   (div_quo)
  );

endmodule

[hw/rtl/key_twinkle_color_generator_top.sv]
// ----------------------------------------------------------------------------
// key_twinkle_color_generator_top
// Per-key twinkle colour: hashed phase, sine wave, density threshold,
// smoothstep and background-to-star blend.
// Throughput: one transaction per clock while m_axis_tready and the internal queue do not
// hold the flow, set by the fully pipelined multipliers and the 17-stage
// one-bit-per-stage brightness divider.
// Reset: clears all valid flags and the queue, loads register defaults;
// configuration writes are taken every cycle outside reset.
// ----------------------------------------------------------------------------
module key_twinkle_color_generator_top import ktc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key_index[7:0], time_stamp[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // key_out, red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  ktc_cfg_t  cfg;
  logic      push, pop, queue_full, queue_empty;
  ktc_item_t push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.star_red     <= 8'd255;
      cfg.star_green   <= 8'd255;
      cfg.star_blue    <= 8'd255;
      cfg.back_red     <= 8'd0;
      cfg.back_green   <= 8'd0;
      cfg.back_blue    <= 8'd0;
      cfg.lit_fraction <= 17'd16384;
      cfg.rate_scale   <= 16'd256;
    end else if (cfg_valid) begin
      unique case (ktc_reg_t'(cfg_index))
        REG_STAR_RED:     cfg.star_red     <= cfg_data[7:0];
        REG_STAR_GREEN:   cfg.star_green   <= cfg_data[7:0];
        REG_STAR_BLUE:    cfg.star_blue    <= cfg_data[7:0];
        REG_BACK_RED:     cfg.back_red     <= cfg_data[7:0];
        REG_BACK_GREEN:   cfg.back_green   <= cfg_data[7:0];
        REG_BACK_BLUE:    cfg.back_blue    <= cfg_data[7:0];
        REG_LIT_FRACTION: cfg.lit_fraction <= cfg_data;
        REG_RATE_SCALE:   cfg.rate_scale   <= cfg_data[15:0];
        default:          cfg.rate_scale   <= cfg.rate_scale;
      endcase
    end
  end

  ktc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_key     (s_axis_tdata[7:0]),
    .in_stamp   (s_axis_tdata[39:8]),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  ktc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (queue_empty)
  );

  ktc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_key   (m_axis_tdata[7:0]),
    .out_red   (m_axis_tdata[15:8]),
    .out_green (m_axis_tdata[23:16]),
    .out_blue  (m_axis_tdata[31:24])
  );

endmodule
